>>> sv/assert_macros.svh
// Assertion macros used by the box drop RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> sv/hbd_pkg.sv
// Package: payload types, status codes and control program of the box drop block.
`timescale 1ns / 1ps

package hbd_pkg;

  typedef struct packed {
    logic [4:0] corner_x;
    logic [4:0] corner_y;
    logic [5:0] box_width;
    logic [5:0] box_length;
    logic [9:0] box_height;
  } in_item_t;

  typedef struct packed {
    logic [15:0] floor_level;
    logic [15:0] top_level;
    logic [1:0]  status;
  } out_item_t;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OUTSIDE   = 2'd1;
  localparam logic [1:0] ST_SATURATED = 2'd2;

  typedef enum logic [7:0] {
    ACT_CLEAR = 8'b0000_0001,
    ACT_IDLE  = 8'b0000_0010,
    ACT_CHECK = 8'b0000_0100,
    ACT_READ  = 8'b0000_1000,
    ACT_DRAIN = 8'b0001_0000,
    ACT_TOP   = 8'b0010_0000,
    ACT_WRITE = 8'b0100_0000,
    ACT_POST  = 8'b1000_0000
  } act_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_CLEARING,
    C_NO_INPUT,
    C_OUTSIDE,
    C_MORE_CELLS,
    C_OUT_BUSY
  } cond_t;

  typedef logic [2:0] step_t;

  localparam step_t STEP_CLEAR = 3'd0;
  localparam step_t STEP_IDLE  = 3'd1;
  localparam step_t STEP_CHECK = 3'd2;
  localparam step_t STEP_READ  = 3'd3;
  localparam step_t STEP_DRAIN = 3'd4;
  localparam step_t STEP_TOP   = 3'd5;
  localparam step_t STEP_WRITE = 3'd6;
  localparam step_t STEP_POST  = 3'd7;

  localparam int NUM_STEPS = 8;

  // jmp is taken when cond holds, nxt otherwise
  typedef struct packed {
    act_t  act;
    cond_t cond;
    step_t jmp;
    step_t nxt;
  } ctrl_t;

  localparam ctrl_t PROGRAM [NUM_STEPS] = '{
    '{act: ACT_CLEAR, cond: C_CLEARING,   jmp: STEP_CLEAR, nxt: STEP_IDLE},
    '{act: ACT_IDLE,  cond: C_NO_INPUT,   jmp: STEP_IDLE,  nxt: STEP_CHECK},
    '{act: ACT_CHECK, cond: C_OUTSIDE,    jmp: STEP_POST,  nxt: STEP_READ},
    '{act: ACT_READ,  cond: C_MORE_CELLS, jmp: STEP_READ,  nxt: STEP_DRAIN},
    '{act: ACT_DRAIN, cond: C_NEVER,      jmp: STEP_DRAIN, nxt: STEP_TOP},
    '{act: ACT_TOP,   cond: C_NEVER,      jmp: STEP_TOP,   nxt: STEP_WRITE},
    '{act: ACT_WRITE, cond: C_MORE_CELLS, jmp: STEP_WRITE, nxt: STEP_POST},
    '{act: ACT_POST,  cond: C_OUT_BUSY,   jmp: STEP_POST,  nxt: STEP_IDLE}
  };

endpackage

>>> sv/heightmap_box_drop_top.sv
// Height map box drop block: microcoded sequencer over a single map memory.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Drops boxes onto a MAP_WIDTH x MAP_LENGTH height map and returns, per box,
// the resting floor, the new top and a status. After reset the map is cleared
// by a pass over all MAP_WIDTH*MAP_LENGTH cells, one cell a cycle, during which
// no item is taken. A box is worked in one read pass and one write pass over
// the cells of its footprint through the single map port, plus five control
// steps; a box outside the map skips both passes. One item is worked on at a
// time; a finished result waits in the output register while the next item is
// taken.
module heightmap_box_drop_top #(
  parameter int MAP_WIDTH   = 32,
  parameter int MAP_LENGTH  = 32,
  parameter int SCALE       = 1,
  parameter int HEIGHT_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  hbd_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output hbd_pkg::out_item_t out_data
);
  import hbd_pkg::*;

  localparam int DEPTH  = MAP_WIDTH * MAP_LENGTH;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW     = (HEIGHT_BITS >= 16) ? 16 : HEIGHT_BITS;
  localparam int DW     = 6 + $clog2(SCALE + 1);
  localparam int HW     = 10 + $clog2(SCALE + 1);
  localparam int CMP_W  = DW + 2;
  localparam int SUM_W  = ((CW > HW) ? CW : HW) + 1;
  localparam int PROD_W = AW + 6;

  step_t              step;
  step_t              step_next;
  ctrl_t              cw;
  logic               cond_hit;

  in_item_t           item;
  logic [AW-1:0]      clr_addr;
  logic [AW-1:0]      addr;
  logic [AW-1:0]      row_base;
  logic [AW-1:0]      addr0;
  logic [DW-1:0]      xi;
  logic [DW-1:0]      yi;
  logic [CW-1:0]      floor_r;
  logic [CW-1:0]      top_r;
  logic [1:0]         status_r;
  logic [CW-1:0]      rdata;
  logic               rd_pend;
  logic [CW-1:0]      mem [DEPTH];

  logic [DW-1:0]      bw_s;
  logic [DW-1:0]      bl_s;
  logic [HW-1:0]      bh_s;
  logic               outside;
  logic               last_cell;
  logic               row_end;
  logic [PROD_W-1:0]  start_full;
  logic [AW:0]        row_step;
  logic [SUM_W-1:0]   top_sum;
  logic               in_xfer;
  logic               out_free;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [CW-1:0]      wr_data;

  assign cw       = PROGRAM[step];
  assign in_stall = (cw.act != ACT_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !(out_valid && out_stall);

  assign bw_s = DW'(item.box_width) * DW'(SCALE);
  assign bl_s = DW'(item.box_length) * DW'(SCALE);
  assign bh_s = HW'(item.box_height) * HW'(SCALE);

  assign outside = (bw_s == '0) || (bl_s == '0) ||
                   (CMP_W'(item.corner_x) + CMP_W'(bw_s) > CMP_W'(MAP_WIDTH)) ||
                   (CMP_W'(item.corner_y) + CMP_W'(bl_s) > CMP_W'(MAP_LENGTH));

  assign start_full = PROD_W'(item.corner_x) * PROD_W'(MAP_LENGTH) + PROD_W'(item.corner_y);
  assign row_step   = (AW + 1)'(row_base) + (AW + 1)'(MAP_LENGTH);
  assign row_end    = (yi == bl_s - DW'(1));
  assign last_cell  = row_end && (xi == bw_s - DW'(1));
  assign top_sum    = SUM_W'(floor_r) + SUM_W'(bh_s);

  always_comb begin
    case (cw.cond)
      C_NEVER:      cond_hit = 1'b0;
      C_CLEARING:   cond_hit = (clr_addr != AW'(DEPTH - 1));
      C_NO_INPUT:   cond_hit = !in_xfer;
      C_OUTSIDE:    cond_hit = outside;
      C_MORE_CELLS: cond_hit = !last_cell;
      C_OUT_BUSY:   cond_hit = !out_free;
      default:      cond_hit = 1'b0;
    endcase
    step_next = cond_hit ? cw.jmp : cw.nxt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step     <= STEP_CLEAR;
      clr_addr <= '0;
    end else begin
      step <= step_next;
      if (cw.act == ACT_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
    end
  end

  // map memory, one port
  assign wr_en   = (cw.act == ACT_CLEAR) || (cw.act == ACT_WRITE);
  assign wr_addr = (cw.act == ACT_CLEAR) ? clr_addr : addr;
  assign wr_data = (cw.act == ACT_CLEAR) ? '0 : top_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cw.act == ACT_READ) begin
      rdata <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= (cw.act == ACT_READ);
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rd_pend && (rdata > floor_r)) begin
      floor_r <= rdata;
    end
    case (cw.act)
      ACT_IDLE: begin
        if (in_xfer) begin
          item <= in_data;
        end
      end
      ACT_CHECK: begin
        addr     <= start_full[AW-1:0];
        row_base <= start_full[AW-1:0];
        addr0    <= start_full[AW-1:0];
        xi       <= '0;
        yi       <= '0;
        floor_r  <= '0;
        top_r    <= '0;
        status_r <= outside ? ST_OUTSIDE : ST_OK;
      end
      ACT_READ, ACT_WRITE: begin
        if (row_end) begin
          yi       <= '0;
          xi       <= xi + DW'(1);
          row_base <= row_step[AW-1:0];
          addr     <= row_step[AW-1:0];
        end else begin
          yi   <= yi + DW'(1);
          addr <= addr + AW'(1);
        end
      end
      ACT_DRAIN: begin
        addr     <= addr0;
        row_base <= addr0;
        xi       <= '0;
        yi       <= '0;
      end
      ACT_TOP: begin
        if (top_sum > SUM_W'((64'd1 << CW) - 64'd1)) begin
          top_r    <= '1;
          status_r <= ST_SATURATED;
        end else begin
          top_r <= top_sum[CW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((cw.act == ACT_POST) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((cw.act == ACT_POST) && out_free) begin
      out_data.floor_level <= 16'(floor_r);
      out_data.top_level   <= 16'(top_r);
      out_data.status      <= status_r;
    end
  end

  `ASSERT_NEXT(a_read_to_drain, clk, rst, (step == STEP_READ) && last_cell, step == STEP_DRAIN)
  `ASSERT_IMPL(a_top_over_floor, clk, rst, step == STEP_POST, top_r >= floor_r)
  `ASSERT_IMPL(a_wr_in_range, clk, rst, wr_en, 32'(wr_addr) < 32'(DEPTH))

endmodule

>>> verif/heightmap_box_drop_top_tb.sv
// Self-checking bench for the box drop block: directed drops from a table, then random drops and tower drops.
`timescale 1ns / 1ps

module heightmap_box_drop_top_tb;
  import hbd_pkg::*;

  localparam int MAP_W = 32;
  localparam int MAP_L = 32;
  localparam int SCALE = 1;
  localparam int HEIGHT_BITS = 16;
  localparam int unsigned HEIGHT_CAP =
    (HEIGHT_BITS >= 16) ? 32'hFFFF : (32'd1 << HEIGHT_BITS) - 32'd1;
  localparam int RANDOM_DROPS = 500;
  localparam int TOWER_DROPS = 80;
  localparam int LONG_HOLD = 400;

  typedef struct {
    in_item_t  box;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  logic [15:0] heights [MAP_W][MAP_L];
  out_item_t   pending_drops [$];
  int          mismatch_count = 0;
  bit          calm = 1'b0;
  bit          long_hold = 1'b0;

  heightmap_box_drop_top #(
    .MAP_WIDTH  (MAP_W),
    .MAP_LENGTH (MAP_L),
    .SCALE      (SCALE),
    .HEIGHT_BITS(HEIGHT_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic out_item_t drop_box(in_item_t box);
    out_item_t   res;
    int unsigned cx, cy, w, l, h, lo, hi, x, y;
    cx = 32'(box.corner_x);
    cy = 32'(box.corner_y);
    w = 32'(box.box_width) * SCALE;
    l = 32'(box.box_length) * SCALE;
    h = 32'(box.box_height) * SCALE;
    res = '0;
    if (w == 0 || l == 0 || cx + w > MAP_W || cy + l > MAP_L) begin
      res.status = ST_OUTSIDE;
      return res;
    end
    lo = 0;
    for (x = cx; x < cx + w; x++)
      for (y = cy; y < cy + l; y++)
        if (32'(heights[x][y]) > lo) lo = 32'(heights[x][y]);
    hi = lo + h;
    res.status = ST_OK;
    if (hi > HEIGHT_CAP) begin
      hi = HEIGHT_CAP;
      res.status = ST_SATURATED;
    end
    for (x = cx; x < cx + w; x++)
      for (y = cy; y < cy + l; y++)
        heights[x][y] = 16'(hi);
    res.floor_level = 16'(lo);
    res.top_level = 16'(hi);
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic dir_row_t row(int cx, int cy, int w, int l, int h, bit typed = 1'b0,
                                   int fl = 0, int tp = 0, logic [1:0] st = ST_OK);
    dir_row_t r;
    r.box.corner_x = 5'(cx);
    r.box.corner_y = 5'(cy);
    r.box.box_width = 6'(w);
    r.box.box_length = 6'(l);
    r.box.box_height = 10'(h);
    r.typed = typed;
    r.want.floor_level = 16'(fl);
    r.want.top_level = 16'(tp);
    r.want.status = st;
    return r;
  endfunction

  function automatic in_item_t random_box();
    in_item_t b;
    int       r;
    r = $urandom_range(0, 99);
    b.box_height = ($urandom_range(0, 19) == 0) ? 10'd0 : 10'($urandom_range(0, 1023));
    if (r < 12) begin
      b.corner_x = 5'($urandom);
      b.corner_y = 5'($urandom);
      b.box_width = 6'($urandom);
      b.box_length = 6'($urandom);
    end else begin
      if (r < 17) begin
        b.box_width = 6'($urandom_range(16, MAP_W));
        b.box_length = 6'($urandom_range(16, MAP_L));
      end else begin
        b.box_width = 6'($urandom_range(1, 4));
        b.box_length = 6'($urandom_range(1, 4));
      end
      b.corner_x = 5'($urandom_range(0, MAP_W - 32'(b.box_width)));
      b.corner_y = 5'($urandom_range(0, MAP_L - 32'(b.box_length)));
    end
    return b;
  endfunction

  // one transfer; the prediction is made once in_stall is seen low after an edge
  task automatic offer(input in_item_t box, input bit typed, input out_item_t want);
    int        gap;
    out_item_t predicted;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= box;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = drop_box(box);
    pending_drops.insert(pending_drops.size(), typed ? want : predicted);
  endtask

  // count stacked drops on one small spot, driving the height range into saturation
  task automatic build_tower(input int count);
    in_item_t b;
    int       k;
    b.box_width = 6'($urandom_range(1, 2));
    b.box_length = 6'($urandom_range(1, 2));
    b.corner_x = 5'($urandom_range(0, MAP_W - 2));
    b.corner_y = 5'($urandom_range(0, MAP_L - 2));
    for (k = 0; k < count; k++) begin
      b.box_height = 10'($urandom_range(900, 1023));
      offer(b, 1'b0, '0);
    end
  endtask

  initial begin
    int stall_len;
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        stall_len = LONG_HOLD;
      end else begin
        stall_len = pick_gap();
      end
      if (stall_len > 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_drops.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: floor %0d top %0d status %0d",
                   out_data.floor_level, out_data.top_level, out_data.status);
      end else begin
        want = pending_drops.pop_front();
        if (out_data.floor_level !== want.floor_level ||
            out_data.top_level !== want.top_level ||
            out_data.status !== want.status) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected floor %0d top %0d status %0d, got %0d %0d %0d",
                     want.floor_level, want.top_level, want.status,
                     out_data.floor_level, out_data.top_level, out_data.status);
        end
      end
    end
  end

  initial begin
    dir_row_t steps [$];
    int       sent;
    foreach (heights[x, y]) heights[x][y] = '0;
    steps = '{
      row(0, 0, 1, 1, 1, 1'b1, 0, 1, ST_OK),
      row(0, 0, 0, 1, 5, 1'b1, 0, 0, ST_OUTSIDE),
      row(0, 0, 1, 0, 5, 1'b1, 0, 0, ST_OUTSIDE),
      row(31, 0, 2, 1, 5, 1'b1, 0, 0, ST_OUTSIDE),
      row(0, 31, 1, 2, 5, 1'b1, 0, 0, ST_OUTSIDE),
      row(31, 31, 63, 63, 1023, 1'b1, 0, 0, ST_OUTSIDE),
      row(31, 31, 1, 1, 1023, 1'b1, 0, 1023, ST_OK),
      row(31, 0, 1, 32, 0, 1'b1, 1023, 1023, ST_OK),
      row(0, 0, 32, 32, 0, 1'b1, 1023, 1023, ST_OK),
      row(0, 0, 32, 32, 1023, 1'b1, 1023, 2046, ST_OK),
      row(1, 1, 1, 1, 1, 1'b1, 2046, 2047, ST_OK),
      row(0, 0, 32, 1, 682),
      row(0, 0, 1, 32, 341),
      row(16, 16, 16, 16, 1023),
      row(10, 20, 5, 12, 0),
      row(21, 0, 11, 32, 512),
      row(0, 21, 32, 11, 256),
      row(0, 0, 33, 1, 1, 1'b1, 0, 0, ST_OUTSIDE),
      row(0, 0, 1, 33, 1, 1'b1, 0, 0, ST_OUTSIDE),
      row(31, 31, 1, 1, 0),
      row(15, 7, 3, 9, 1),
      row(30, 30, 2, 2, 1023)
    };
    while (rst) @(posedge clk);
    foreach (steps[i]) offer(steps[i].box, steps[i].typed, steps[i].want);

    sent = 0;
    while (sent < RANDOM_DROPS) begin
      if (sent % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      if (sent == 100) long_hold = 1'b1;
      if (sent == 250) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_drops.size() != 0);
      end
      if (sent == 150 || sent == 380) begin
        build_tower(TOWER_DROPS);
        sent += TOWER_DROPS;
      end else begin
        offer(random_box(), 1'b0, '0);
        sent++;
      end
    end
    in_valid <= 1'b0;

    while (pending_drops.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> heightmap_box_drop_top.f
+incdir+sv
sv/hbd_pkg.sv
sv/heightmap_box_drop_top.sv
verif/heightmap_box_drop_top_tb.sv
